// ===== src/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg - shared types and constants of the table interpolator
// Table geometry, register indexes, and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int XW_W       = DATA_W + 2;       // query x after wrap
    localparam int HALF_W     = XW_W / 2;         // partial product split
    localparam int PROD_W     = XW_W + DATA_W;    // |dx| * |dy|
    localparam int SUM_W      = DATA_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC    = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
    localparam logic MODE_HOLD = 1'b1;

    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_MID,
        ADDR_IDX,
        ADDR_SEG,
        ADDR_SEG1
    } t_addr_sel;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_Y0,
        RES_YA,
        RES_AVG,
        RES_SEG
    } t_res_sel;

    typedef struct packed {
        logic      load_q;
        logic      wr;
        logic      rd;
        t_addr_sel addr_sel;
        logic      cap_ends;
        logic      cap_last;
        logic      wrap_start;
        logic      wrap_apply;
        logic      srch_init;
        logic      srch_step;
        logic      cap_a;
        logic      cap_b;
        logic      cap_c;
        logic      prep;
        logic      mul1;
        logic      mul2;
        logic      div_start;
        logic      fin;
        t_res_sel  res_sel;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic periodic;
        logic hold;
        logic span_zero;
        logic srch_open;
        logic hit;
        logic same_x;
        logic div_done;
    } t_status;

endpackage

`default_nettype wire

// ===== src/tli_div.sv =====
// ----------------------------------------------------------------------------
// tli_div - serial restoring divider
// One quotient bit per cycle; unsigned magnitudes, quotient and remainder
// held after the done strobe until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tli_pkg::PROD_W-1:0]    i_dividend,
    input  wire logic [tli_pkg::DATA_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [tli_pkg::PROD_W-1:0]         o_quotient,
    output logic [tli_pkg::DATA_W-1:0]         o_remainder
);

    localparam int CNT_BITS = $clog2(tli_pkg::PROD_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_BITS-1:0]         r_cnt;
    logic [tli_pkg::PROD_W-1:0]  r_quo;
    logic [tli_pkg::DATA_W-1:0]  r_rem;
    logic [tli_pkg::DATA_W-1:0]  r_dvs;
    logic [tli_pkg::DATA_W:0]    n_trial;
    logic                        n_ge;

    assign n_trial = {r_rem, r_quo[tli_pkg::PROD_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(tli_pkg::PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tli_pkg::PROD_W-2:0], n_ge};
            r_rem <= n_ge ? tli_pkg::DATA_W'(n_trial - {1'b0, r_dvs})
                          : n_trial[tli_pkg::DATA_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== src/tli_dp.sv =====
// ----------------------------------------------------------------------------
// tli_dp - interpolator datapath
// Breakpoint memories, configuration registers, search bounds, segment
// arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tli_pkg::t_cmd                    i_cmd,
    input  wire logic [tli_pkg::ADDR_W-1:0]       i_point_index,
    input  wire logic [tli_pkg::DATA_W-1:0]       i_x_value,
    input  wire logic [tli_pkg::DATA_W-1:0]       i_y_value,
    input  wire logic                             i_cfg_we,
    input  wire logic [tli_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tli_pkg::CFG_W-1:0]        i_cfg_data,
    output tli_pkg::t_status                      o_status,
    output logic [tli_pkg::DATA_W-1:0]            o_result_value,
    output logic                                  o_saturated,
    output logic                                  o_result_valid
);

    localparam int DW  = tli_pkg::DATA_W;
    localparam int XW  = tli_pkg::XW_W;
    localparam int HW  = tli_pkg::HALF_W;
    localparam int PW  = tli_pkg::PROD_W;
    localparam int SW  = tli_pkg::SUM_W;
    localparam int CW  = tli_pkg::CNT_W;
    localparam int AW  = tli_pkg::ADDR_W;
    localparam logic [SW-1:0] SUM_MAX = SW'({1'b0, {(DW-1){1'b1}}});
    localparam logic [SW-1:0] SUM_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};

    logic [DW-1:0] x_mem [tli_pkg::MAX_POINTS];
    logic [DW-1:0] y_mem [tli_pkg::MAX_POINTS];

    logic [tli_pkg::CFG_W-1:0] r_point_count;
    logic                      r_mode;
    logic                      r_periodic;

    logic [DW-1:0] r_xrd, r_yrd;
    logic [DW-1:0] r_x0, r_y0, r_xl, r_xa, r_ya, r_x1, r_y1, r_x2, r_y2;
    logic [XW-1:0] r_x;
    logic [CW-1:0] r_lo, r_hi;
    logic [XW-1:0] r_adx;
    logic [DW-1:0] r_ady, r_ad;
    logic          r_neg;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_res;
    logic          r_sat;
    logic          r_done;

    logic [CW-1:0]  n_cnt, n_last, n_mid, n_idx, n_seg, n_seg1;
    logic [AW-1:0]  n_addr;
    logic [DW:0]    n_span;
    logic [DW-1:0]  n_span_mag, n_xmag;
    logic [XW-1:0]  n_xabs, n_wrap;
    logic [XW:0]    n_dx;
    logic [DW:0]    n_dy, n_d;
    logic [HW+DW-1:0] n_pp;
    logic           n_div_start, n_div_done;
    logic [PW-1:0]  n_dividend, n_quo;
    logic [DW-1:0]  n_divisor, n_rem;
    logic [DW:0]    n_ysum, n_avg;
    logic [SW-1:0]  n_qs, n_sum;
    logic [DW-1:0]  n_res;
    logic           n_sat;

    // count clamp and search pointers
    assign n_cnt  = (r_point_count > CW'(tli_pkg::MAX_POINTS))
                  ? CW'(tli_pkg::MAX_POINTS) : CW'(r_point_count);
    assign n_last = n_cnt - 1'b1;
    assign n_mid  = CW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign n_idx  = (r_lo == '0) ? '0 : r_lo - 1'b1;
    assign n_seg  = (n_idx == n_last) ? n_idx - 1'b1 : n_idx;
    assign n_seg1 = n_seg + 1'b1;

    always_comb begin
        case (i_cmd.addr_sel)
            tli_pkg::ADDR_ZERO: n_addr = '0;
            tli_pkg::ADDR_LAST: n_addr = n_last[AW-1:0];
            tli_pkg::ADDR_MID:  n_addr = n_mid[AW-1:0];
            tli_pkg::ADDR_IDX:  n_addr = n_idx[AW-1:0];
            tli_pkg::ADDR_SEG:  n_addr = n_seg[AW-1:0];
            tli_pkg::ADDR_SEG1: n_addr = n_seg1[AW-1:0];
            default:            n_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            x_mem[i_point_index] <= i_x_value;
            y_mem[i_point_index] <= i_y_value;
        end
        if (i_cmd.rd) begin
            r_xrd <= x_mem[n_addr];
            r_yrd <= y_mem[n_addr];
        end
    end

    // wrap by the table span
    assign n_span     = {r_xl[DW-1], r_xl} - {r_x0[DW-1], r_x0};
    assign n_span_mag = n_span[DW] ? DW'(-n_span) : n_span[DW-1:0];
    assign n_xabs     = r_x[XW-1] ? -r_x : r_x;
    assign n_xmag     = n_xabs[DW-1:0];

    always_comb begin
        n_wrap = r_x[XW-1] ? -{2'b00, n_rem} : {2'b00, n_rem};
        if ((n_wrap != '0) && (n_wrap[XW-1] != n_span[DW])) begin
            n_wrap = n_wrap + {n_span[DW], n_span};
        end
    end

    // segment deltas
    assign n_dx = {r_x[XW-1], r_x} - {{(XW-DW+1){r_x1[DW-1]}}, r_x1};
    assign n_dy = {r_y2[DW-1], r_y2} - {r_y1[DW-1], r_y1};
    assign n_d  = {r_x2[DW-1], r_x2} - {r_x1[DW-1], r_x1};

    // one shared partial product, low half then high half
    assign n_pp = (i_cmd.mul2 ? r_adx[XW-1:HW] : r_adx[HW-1:0]) * r_ady;

    assign n_div_start = i_cmd.wrap_start | i_cmd.div_start;
    assign n_dividend  = i_cmd.wrap_start ? PW'(n_xmag) : r_prod;
    assign n_divisor   = i_cmd.wrap_start ? n_span_mag : r_ad;

    tli_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_div_start),
        .i_dividend  (n_dividend),
        .i_divisor   (n_divisor),
        .o_done      (n_div_done),
        .o_quotient  (n_quo),
        .o_remainder (n_rem)
    );

    // average of equal-x segment, rounded toward zero
    assign n_ysum = {r_y1[DW-1], r_y1} + {r_y2[DW-1], r_y2};
    assign n_avg  = $signed(n_ysum + (DW+1)'(n_ysum[DW])) >>> 1;

    // y1 +/- quotient with clip
    assign n_qs  = r_neg ? -SW'(n_quo[DW:0]) : SW'(n_quo[DW:0]);
    assign n_sum = {{(SW-DW){r_y1[DW-1]}}, r_y1} + n_qs;

    // the single-point result leaves in the cycle that slot 0 is on the read port
    always_comb begin
        n_sat = 1'b0;
        n_res = '0;
        case (i_cmd.res_sel)
            tli_pkg::RES_ZERO: n_res = '0;
            tli_pkg::RES_Y0:   n_res = r_yrd;
            tli_pkg::RES_YA:   n_res = r_ya;
            tli_pkg::RES_AVG:  n_res = n_avg[DW-1:0];
            tli_pkg::RES_SEG: begin
                if (|n_quo[PW-1:DW+1]) begin
                    n_sat = 1'b1;
                    n_res = r_neg ? RES_MIN : RES_MAX;
                end else if ($signed(n_sum) > $signed(SUM_MAX)) begin
                    n_sat = 1'b1;
                    n_res = RES_MAX;
                end else if ($signed(n_sum) < $signed(SUM_MIN)) begin
                    n_sat = 1'b1;
                    n_res = RES_MIN;
                end else begin
                    n_res = n_sum[DW-1:0];
                end
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_mode        <= 1'b0;
            r_periodic    <= 1'b0;
            r_done        <= 1'b0;
            r_lo          <= '0;
            r_hi          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tli_pkg::REG_POINT_COUNT: r_point_count <= i_cfg_data;
                    tli_pkg::REG_INTERP_MODE: r_mode        <= i_cfg_data[0];
                    tli_pkg::REG_PERIODIC:    r_periodic    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_done <= i_cmd.fin;
            if (i_cmd.srch_init) begin
                r_lo <= '0;
                r_hi <= n_cnt;
            end else if (i_cmd.srch_step) begin
                if ($signed(r_x) >= $signed({{(XW-DW){r_xrd[DW-1]}}, r_xrd})) begin
                    r_lo <= n_mid + 1'b1;
                end else begin
                    r_hi <= n_mid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q) begin
            r_x <= {{(XW-DW){i_x_value[DW-1]}}, i_x_value};
        end else if (i_cmd.wrap_apply) begin
            r_x <= n_wrap;
        end
        if (i_cmd.cap_ends) begin
            r_x0 <= r_xrd;
            r_y0 <= r_yrd;
        end
        if (i_cmd.cap_last) begin
            r_xl <= r_xrd;
        end
        if (i_cmd.cap_a) begin
            r_xa <= r_xrd;
            r_ya <= (r_periodic && (n_idx == n_last)) ? r_y0 : r_yrd;
        end
        if (i_cmd.cap_b) begin
            r_x1 <= r_xrd;
            r_y1 <= r_yrd;
        end
        if (i_cmd.cap_c) begin
            r_x2 <= r_xrd;
            r_y2 <= (r_periodic && (n_seg1 == n_last)) ? r_y0 : r_yrd;
        end
        if (i_cmd.prep) begin
            r_adx <= n_dx[XW] ? XW'(-n_dx) : n_dx[XW-1:0];
            r_ady <= n_dy[DW] ? DW'(-n_dy) : n_dy[DW-1:0];
            r_ad  <= n_d[DW]  ? DW'(-n_d)  : n_d[DW-1:0];
            r_neg <= n_dx[XW] ^ n_dy[DW] ^ n_d[DW];
        end
        if (i_cmd.mul1) begin
            r_prod <= PW'(n_pp);
        end else if (i_cmd.mul2) begin
            r_prod <= r_prod + (PW'(n_pp) << HW);
        end
        if (i_cmd.fin) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_status.n_zero    = (n_cnt == '0);
    assign o_status.n_one     = (n_cnt == CW'(1));
    assign o_status.periodic  = r_periodic;
    assign o_status.hold      = (r_mode == tli_pkg::MODE_HOLD);
    assign o_status.span_zero = (r_xl == r_x0);
    assign o_status.srch_open = (r_lo < r_hi);
    assign o_status.hit       = (r_x == {{(XW-DW){r_xa[DW-1]}}, r_xa});
    assign o_status.same_x    = (r_x1 == r_x2);
    assign o_status.div_done  = n_div_done;

    assign o_result_value = r_res;
    assign o_saturated    = r_sat;
    assign o_result_valid = r_done;

endmodule

`default_nettype wire

// ===== src/tli_ctrl.sv =====
// ----------------------------------------------------------------------------
// tli_ctrl - interpolator sequencer
// Walks one query through end reads, wrap, binary search, segment reads,
// multiply and divide; loads finish in the accept cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_op,
    input  wire tli_pkg::t_status  i_status,
    output tli_pkg::t_cmd          o_cmd,
    output logic                   o_busy
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_RD0   = 16'h0002,
        S_SPAN  = 16'h0004,
        S_CHK   = 16'h0008,
        S_WRAP  = 16'h0010,
        S_PROBE = 16'h0020,
        S_CMP   = 16'h0040,
        S_GETA  = 16'h0080,
        S_DECA  = 16'h0100,
        S_RDC   = 16'h0200,
        S_RDD   = 16'h0400,
        S_SEGC  = 16'h0800,
        S_MUL1  = 16'h1000,
        S_MUL2  = 16'h2000,
        S_DIVS  = 16'h4000,
        S_DIV   = 16'h8000
    } t_state;

    t_state        r_state, n_state;
    tli_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == tli_pkg::OP_LOAD) begin
                        n_cmd.wr = 1'b1;
                    end else begin
                        n_cmd.load_q = 1'b1;
                        if (i_status.n_zero) begin
                            n_cmd.fin     = 1'b1;
                            n_cmd.res_sel = tli_pkg::RES_ZERO;
                        end else begin
                            n_cmd.rd       = 1'b1;
                            n_cmd.addr_sel = tli_pkg::ADDR_ZERO;
                            n_state        = S_RD0;
                        end
                    end
                end
            end
            S_RD0: begin
                n_cmd.cap_ends = 1'b1;
                if (i_status.n_one) begin
                    n_cmd.fin     = 1'b1;
                    n_cmd.res_sel = tli_pkg::RES_Y0;
                    n_state       = S_IDLE;
                end else begin
                    n_cmd.rd       = 1'b1;
                    n_cmd.addr_sel = tli_pkg::ADDR_LAST;
                    n_state        = S_SPAN;
                end
            end
            S_SPAN: begin
                n_cmd.cap_last = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (i_status.periodic && !i_status.span_zero) begin
                    n_cmd.wrap_start = 1'b1;
                    n_state          = S_WRAP;
                end else begin
                    n_cmd.srch_init = 1'b1;
                    n_state         = S_PROBE;
                end
            end
            S_WRAP: begin
                if (i_status.div_done) begin
                    n_cmd.wrap_apply = 1'b1;
                    n_cmd.srch_init  = 1'b1;
                    n_state          = S_PROBE;
                end
            end
            S_PROBE: begin
                n_cmd.rd = 1'b1;
                if (i_status.srch_open) begin
                    n_cmd.addr_sel = tli_pkg::ADDR_MID;
                    n_state        = S_CMP;
                end else begin
                    n_cmd.addr_sel = tli_pkg::ADDR_IDX;
                    n_state        = S_GETA;
                end
            end
            S_CMP: begin
                n_cmd.srch_step = 1'b1;
                n_state         = S_PROBE;
            end
            S_GETA: begin
                n_cmd.cap_a = 1'b1;
                n_state     = S_DECA;
            end
            S_DECA: begin
                if (i_status.hold || i_status.hit) begin
                    n_cmd.fin     = 1'b1;
                    n_cmd.res_sel = tli_pkg::RES_YA;
                    n_state       = S_IDLE;
                end else begin
                    n_cmd.rd       = 1'b1;
                    n_cmd.addr_sel = tli_pkg::ADDR_SEG;
                    n_state        = S_RDC;
                end
            end
            S_RDC: begin
                n_cmd.cap_b    = 1'b1;
                n_cmd.rd       = 1'b1;
                n_cmd.addr_sel = tli_pkg::ADDR_SEG1;
                n_state        = S_RDD;
            end
            S_RDD: begin
                n_cmd.cap_c = 1'b1;
                n_state     = S_SEGC;
            end
            S_SEGC: begin
                if (i_status.same_x) begin
                    n_cmd.fin     = 1'b1;
                    n_cmd.res_sel = tli_pkg::RES_AVG;
                    n_state       = S_IDLE;
                end else begin
                    n_cmd.prep = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                n_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                n_cmd.mul2 = 1'b1;
                n_state    = S_DIVS;
            end
            S_DIVS: begin
                n_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_cmd.fin     = 1'b1;
                    n_cmd.res_sel = tli_pkg::RES_SEG;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == tli_pkg::OP_QUERY) && !i_status.n_zero)
        |=> o_busy)
        else $error("query accepted but sequencer stayed idle");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> ((r_state == S_WRAP) || (r_state == S_DIV)))
        else $error("divider finished outside a wait state");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.fin |=> !o_busy)
        else $error("sequencer still busy after a result");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.wr |-> !o_busy && !n_cmd.rd)
        else $error("table write during a query");
`endif

endmodule

`default_nettype wire

// ===== src/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator - piecewise linear breakpoint table
// Signed Q16.16 lookup with linear, hold and periodic modes.
// ----------------------------------------------------------------------------
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. i_op selects a load (write i_x_value/i_y_value into slot
//   i_point_index) or a query (i_x_value is the abscissa).
//   A load finishes in its accept cycle; busy stays low and no beat comes
//   back. Unless the table is empty, a query raises busy until its result is
//   registered. Result channel: o_result_valid marks a one-cycle beat
//   carrying o_result_value and o_saturated. The receiver cannot stall it.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 point count, 1 mode, 2 periodic) at once; write only while idle.
//   An empty table, one point, hold mode or an exact hit end a query early;
//   a full segment adds the multiply and divide, and periodic mode adds a
//   divide for the wrap. The 66-step serial divider sets the long cases,
//   the single-port table reads set the search.
//   Reset clears the sequencer and config registers; the tables keep garbage
//   until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_op,
    input  wire logic [tli_pkg::ADDR_W-1:0]       i_point_index,
    input  wire logic [tli_pkg::DATA_W-1:0]       i_x_value,
    input  wire logic [tli_pkg::DATA_W-1:0]       i_y_value,
    input  wire logic                             i_cfg_we,
    input  wire logic [tli_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tli_pkg::CFG_W-1:0]        i_cfg_data,
    output logic [tli_pkg::DATA_W-1:0]            o_result_value,
    output logic                                  o_saturated,
    output logic                                  o_result_valid
);

    tli_pkg::t_cmd    cmd;
    tli_pkg::t_status status;

    // sequencer: one query at a time, loads pass straight through
    tli_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // tables, search bounds, arithmetic and the result beat
    tli_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_point_index  (i_point_index),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_result_value (o_result_value),
        .o_saturated    (o_saturated),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire
